/* design/rpc_pkg.sv */
// Package for the picture-unit register port.
// Holds the memory sizes, register and action codes, address constants and
// the command/status structs shared by the controller and the datapath.
package rpc_pkg;

    // Memory sizes
    localparam int NAME_BYTES    = 2048;
    localparam int PATTERN_BYTES = 8192;
    localparam int SPRITE_BYTES  = 256;
    localparam int NAME_AW       = $clog2(NAME_BYTES);
    localparam int PAT_AW        = $clog2(PATTERN_BYTES);
    localparam int SPR_AW        = $clog2(SPRITE_BYTES);

    // Last address of the power-up clearing sweep (largest memory)
    localparam logic [PAT_AW-1:0] CLEAR_LAST = PAT_AW'(PATTERN_BYTES - 1);

    // Action codes
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_LOAD  = 2'd2;

    // Register select codes (offset from 0x2000)
    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR = 3'd3;
    localparam logic [2:0] REG_OAM_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    // VRAM map and constants
    localparam logic [13:0] PAL_BASE     = 14'h3f00;
    localparam logic [7:0]  STATUS_FLAGS = 8'hc0;
    localparam logic [15:0] STEP_WIDE    = 16'd32;
    localparam logic [15:0] STEP_NARROW  = 16'd1;
    localparam int          CTRL_STEP_BIT = 2;

    // Source of the value used in the response cycle
    typedef logic [1:0] rsrc_t;
    localparam rsrc_t SRC_ZERO    = 2'd0;
    localparam rsrc_t SRC_SPRITE  = 2'd1;
    localparam rsrc_t SRC_PATTERN = 2'd2;
    localparam rsrc_t SRC_NAME    = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic              load_item;
        logic              execute;
        logic              respond;
        logic              clear_we;
        logic [PAT_AW-1:0] clear_addr;
    } rpc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_busy;
    } rpc_status_t;

endpackage

/* design/ppu_register_port_core.sv */
// Picture-unit register port: CPU register accesses and pattern loads.
// Top level; instantiates rpc_ctrl and rpc_datapath, uses rpc_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one transfer: action (read,
//   write, pattern byte load), reg_select, data and pattern_address.
//   Output channel (out_valid/out_ready) returns one read_data byte for
//   every transfer, zero for writes and loads.
//   cfg_wr_en/cfg_wr_data set the nametable mirroring mode (reset 1),
//   to be written by the user only while idle; the block does not enforce it.
// Sequencing:
//   After reset a clearing pass zeroes sprite, nametable and pattern
//   memory, one address a cycle; in_ready stays low meanwhile.
//   A transfer passes through accept, execute (register update, memory
//   read launch) and response (registered memory data captured). The
//   result is registered in the output register by the response step; a
//   new transfer is accepted only once the last has left its response step.
//   If the receiver stalls, the result waits in the output register; the
//   next transfer is accepted and executes, and holds in its response
//   step until the output register is free.
module ppu_register_port_core
    import rpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [2:0]  reg_select,
    input  logic [7:0]  data,
    input  logic [12:0] pattern_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data
);

    rpc_cmd_t    cmd;
    rpc_status_t status;

    rpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    rpc_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .action          (action),
        .reg_select      (reg_select),
        .data            (data),
        .pattern_address (pattern_address),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .read_data       (read_data)
    );

endmodule

/* design/rpc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for sprite, nametable and pattern memories.
module rpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/rpc_ctrl.sv */
// Controller for the picture-unit register port.
// Sequences the clearing sweep and each transfer; depends on rpc_pkg.
module rpc_ctrl
    import rpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  rpc_status_t status,
    output rpc_cmd_t    cmd
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_RESP  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [PAT_AW-1:0] clear_cnt_reg, clear_cnt_next;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        clear_cnt_next = clear_cnt_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_we   = 1'b1;
                cmd.clear_addr = clear_cnt_reg;
                if (clear_cnt_reg == CLEAR_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clear_cnt_next = clear_cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = S_RESP;
            end
            S_RESP:
            begin
                // wait for the output slot to free up
                if (!status.out_busy)
                begin
                    cmd.respond = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clear_cnt_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_cnt_reg <= clear_cnt_next;
        end
    end

`ifndef ASSERT_OFF
    // an accepted transfer always executes next
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_EXEC))
        else $error("accepted transfer did not execute");

    // nothing is accepted before the sweep has covered every address
    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && state_next == S_IDLE) |-> (clear_cnt_reg == CLEAR_LAST))
        else $error("clearing sweep ended early");

    // execute is followed by the response state
    a_exec_resp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |=> (state_reg == S_RESP))
        else $error("execute not followed by response");
`endif

endmodule

/* design/rpc_datapath.sv */
// Datapath for the picture-unit register port: register file, VRAM
// decode, sprite/nametable/pattern memories and output register.
// Depends on rpc_pkg and rpc_ram.
module rpc_datapath
    import rpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  rpc_cmd_t    cmd,
    output rpc_status_t status,
    input  logic [1:0]  action,
    input  logic [2:0]  reg_select,
    input  logic [7:0]  data,
    input  logic [12:0] pattern_address,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data
);

    // Captured transfer
    logic [1:0]        act_reg;
    logic [2:0]        sel_reg;
    logic [7:0]        data_reg;
    logic [PAT_AW-1:0] paddr_reg;

    // Architectural registers
    logic        mirror_mode_reg;
    logic [7:0]  control_reg, control_next;
    logic [7:0]  mask_reg, mask_next;
    logic [7:0]  scroll_x_reg, scroll_x_next;
    logic [7:0]  scroll_y_reg, scroll_y_next;
    logic        second_write_reg, second_write_next;
    logic [15:0] vram_address_reg, vram_address_next;
    logic [7:0]  read_buffer_reg, read_buffer_next;
    logic        status_phase_reg, status_phase_next;
    logic [SPR_AW-1:0] sprite_address_reg, sprite_address_next;

    // Response staging
    logic [7:0] res_reg, res_next;
    rsrc_t      src_reg, src_next;
    logic       buf_load_reg, buf_load_next;

    // Output register
    logic       out_valid_reg;
    logic [7:0] read_data_reg;

    // Memory ports
    logic              spr_we, name_we, pat_we;
    logic [SPR_AW-1:0] spr_waddr;
    logic [NAME_AW-1:0] name_waddr, name_idx;
    logic [PAT_AW-1:0] pat_waddr;
    logic [7:0]        spr_wdata, name_wdata, pat_wdata;
    logic [7:0]        spr_rd, name_rd, pat_rd;

    // Address decode
    logic [13:0] vaddr;
    logic        in_pattern, in_name, name_bank;
    logic [15:0] step_amt;
    logic        is_rd, is_wr, is_ld;
    logic [7:0]  resp_value;

    assign vaddr      = vram_address_reg[13:0];
    assign in_pattern = ~vaddr[13];
    assign in_name    = vaddr[13] && (vaddr < PAL_BASE);
    // bank from the 1 KiB quadrant: vertical uses the high bit, horizontal the low
    assign name_bank  = mirror_mode_reg ? vaddr[10] : vaddr[11];
    assign name_idx   = {name_bank, vaddr[9:0]};
    assign step_amt   = control_reg[CTRL_STEP_BIT] ? STEP_WIDE : STEP_NARROW;

    assign is_rd = cmd.execute && (act_reg == ACT_READ);
    assign is_wr = cmd.execute && (act_reg == ACT_WRITE);
    assign is_ld = cmd.execute && (act_reg == ACT_LOAD);

    // Register updates for the executing transfer
    always_comb
    begin
        control_next        = control_reg;
        mask_next           = mask_reg;
        scroll_x_next       = scroll_x_reg;
        scroll_y_next       = scroll_y_reg;
        second_write_next   = second_write_reg;
        vram_address_next   = vram_address_reg;
        status_phase_next   = status_phase_reg;
        sprite_address_next = sprite_address_reg;
        res_next            = res_reg;
        src_next            = src_reg;
        // reload strobe lasts only the cycle after execute
        buf_load_next       = 1'b0;
        if (cmd.execute)
        begin
            res_next      = 8'd0;
            src_next      = SRC_ZERO;
            buf_load_next = 1'b0;
        end
        if (is_rd)
        begin
            case (sel_reg)
                REG_STATUS:
                begin
                    res_next          = status_phase_reg ? 8'd0 : STATUS_FLAGS;
                    status_phase_next = ~status_phase_reg;
                    second_write_next = 1'b0;
                end
                REG_OAM_DATA:
                begin
                    src_next = SRC_SPRITE;
                end
                REG_DATA:
                begin
                    // old buffer goes out, buffer reloads in the cycle after execute
                    res_next          = read_buffer_reg;
                    buf_load_next     = 1'b1;
                    src_next          = in_pattern ? SRC_PATTERN :
                                        (in_name ? SRC_NAME : SRC_ZERO);
                    vram_address_next = vram_address_reg + step_amt;
                end
                default:
                begin
                end
            endcase
        end
        if (is_wr)
        begin
            case (sel_reg)
                REG_CTRL:     control_next = data_reg;
                REG_MASK:     mask_next = data_reg;
                REG_OAM_ADDR: sprite_address_next = data_reg;
                REG_OAM_DATA: sprite_address_next = sprite_address_reg + 1'b1;
                REG_SCROLL:
                begin
                    if (!second_write_reg)
                    begin
                        scroll_x_next = data_reg;
                    end
                    else
                    begin
                        scroll_y_next = data_reg;
                    end
                    second_write_next = ~second_write_reg;
                end
                REG_ADDR:
                begin
                    if (!second_write_reg)
                    begin
                        vram_address_next = {data_reg, vram_address_reg[7:0]};
                    end
                    else
                    begin
                        vram_address_next = {vram_address_reg[15:8], data_reg};
                    end
                    second_write_next = ~second_write_reg;
                end
                REG_DATA:     vram_address_next = vram_address_reg + step_amt;
                default:
                begin
                end
            endcase
        end
    end

    // Buffer reload from the memory read launched during execute
    always_comb
    begin
        read_buffer_next = read_buffer_reg;
        if (buf_load_reg)
        begin
            case (src_reg)
                SRC_PATTERN: read_buffer_next = pat_rd;
                SRC_NAME:    read_buffer_next = name_rd;
                default:     read_buffer_next = 8'd0;
            endcase
        end
    end

    assign resp_value = (src_reg == SRC_SPRITE) ? spr_rd : res_reg;

    // Memory write ports; the clearing sweep takes priority
    assign spr_we     = cmd.clear_we || (is_wr && (sel_reg == REG_OAM_DATA));
    assign spr_waddr  = cmd.clear_we ? cmd.clear_addr[SPR_AW-1:0] : sprite_address_reg;
    assign spr_wdata  = cmd.clear_we ? 8'd0 : data_reg;

    // palette space is not readable through the data port, so palette
    // writes have no visible effect and are dropped here
    assign name_we    = cmd.clear_we || (is_wr && (sel_reg == REG_DATA) && in_name);
    assign name_waddr = cmd.clear_we ? cmd.clear_addr[NAME_AW-1:0] : name_idx;
    assign name_wdata = cmd.clear_we ? 8'd0 : data_reg;

    assign pat_we     = cmd.clear_we || is_ld;
    assign pat_waddr  = cmd.clear_we ? cmd.clear_addr : paddr_reg;
    assign pat_wdata  = cmd.clear_we ? 8'd0 : data_reg;

    rpc_ram #(.WIDTH(8), .DEPTH(SPRITE_BYTES)) u_sprite_ram (
        .clk   (clk),
        .we    (spr_we),
        .waddr (spr_waddr),
        .wdata (spr_wdata),
        .raddr (sprite_address_reg),
        .rdata (spr_rd)
    );

    rpc_ram #(.WIDTH(8), .DEPTH(NAME_BYTES)) u_name_ram (
        .clk   (clk),
        .we    (name_we),
        .waddr (name_waddr),
        .wdata (name_wdata),
        .raddr (name_idx),
        .rdata (name_rd)
    );

    rpc_ram #(.WIDTH(8), .DEPTH(PATTERN_BYTES)) u_pattern_ram (
        .clk   (clk),
        .we    (pat_we),
        .waddr (pat_waddr),
        .wdata (pat_wdata),
        .raddr (vaddr[PAT_AW-1:0]),
        .rdata (pat_rd)
    );

    // Transfer capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            act_reg   <= action;
            sel_reg   <= reg_select;
            data_reg  <= data;
            paddr_reg <= pattern_address;
        end
        if (cmd.respond)
        begin
            read_data_reg <= resp_value;
        end
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_mode_reg    <= 1'b1;
            control_reg        <= '0;
            mask_reg           <= '0;
            scroll_x_reg       <= '0;
            scroll_y_reg       <= '0;
            second_write_reg   <= 1'b0;
            vram_address_reg   <= '0;
            read_buffer_reg    <= '0;
            status_phase_reg   <= 1'b0;
            sprite_address_reg <= '0;
            res_reg            <= '0;
            src_reg            <= SRC_ZERO;
            buf_load_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mirror_mode_reg <= cfg_wr_data;
            end
            control_reg        <= control_next;
            mask_reg           <= mask_next;
            scroll_x_reg       <= scroll_x_next;
            scroll_y_reg       <= scroll_y_next;
            second_write_reg   <= second_write_next;
            vram_address_reg   <= vram_address_next;
            read_buffer_reg    <= read_buffer_next;
            status_phase_reg   <= status_phase_next;
            sprite_address_reg <= sprite_address_next;
            res_reg            <= res_next;
            src_reg            <= src_next;
            buf_load_reg       <= buf_load_next;
            if (cmd.respond)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign read_data       = read_data_reg;
    assign status.out_busy = out_valid_reg && !out_ready;

`ifndef ASSERT_OFF
    // a response never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.respond |-> !(out_valid_reg && !out_ready))
        else $error("response overwrote pending result");

    // status read flips the phase and clears the write toggle
    a_status_read: assert property (@(posedge clk) disable iff (!rst_n)
        (is_rd && (sel_reg == REG_STATUS)) |=>
        ((status_phase_reg != $past(status_phase_reg)) && !second_write_reg))
        else $error("status read side effects wrong");

    // every data port access steps the VRAM address
    a_data_step: assert property (@(posedge clk) disable iff (!rst_n)
        ((is_rd || is_wr) && (sel_reg == REG_DATA)) |=>
        (vram_address_reg == $past(vram_address_reg) + $past(step_amt)))
        else $error("data port address did not step");

    // sprite data write advances the sprite address by one
    a_oam_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (is_wr && (sel_reg == REG_OAM_DATA)) |=>
        (sprite_address_reg == $past(sprite_address_reg) + 1'b1))
        else $error("sprite address did not advance");
`endif

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for ppu_register_port_core: directed and random CPU register traffic,
// checked against an in-bench model of the registers, VRAM map and memories.
// Depends on rpc_pkg and the design sources only.
module tb_top;
    import rpc_pkg::*;

    localparam logic [1:0]  ACT_NONE     = 2'd3;      // unused action code
    localparam logic [13:0] NAME_BASE    = 14'h2000;
    localparam logic [13:0] PAL_END      = 14'h3f20;
    localparam logic        MIRROR_VERT  = 1'b0;
    localparam logic        MIRROR_HORIZ = 1'b1;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_SHOWN    = 10;
    localparam int TIMEOUT_NS   = 800000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [2:0]  reg_select;
    logic [7:0]  data;
    logic [12:0] pattern_address;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  read_data;
    logic        cfg_wr_en;
    logic        cfg_wr_data;

    ppu_register_port_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .reg_select      (reg_select),
        .data            (data),
        .pattern_address (pattern_address),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .read_data       (read_data),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data)
    );

    // Model state of the register port
    logic        pu_mirror;
    logic [7:0]  pu_ctrl;
    logic [7:0]  pu_mask;
    logic [7:0]  pu_scroll_x;
    logic [7:0]  pu_scroll_y;
    logic        pu_latch_hi;
    logic [15:0] pu_vaddr;
    logic [7:0]  pu_rbuf;
    logic        pu_status_phase;
    logic [7:0]  pu_oam_addr;
    logic [7:0]  oam_mem [SPRITE_BYTES];
    logic [7:0]  nt_mem  [NAME_BYTES];
    logic [7:0]  pal_mem [32];
    logic [7:0]  chr_mem [PATTERN_BYTES];

    logic [7:0]  exp_read_q [$];
    int          fail_count = 0;
    int          items_sent = 0;
    int          burst_left = 0;
    logic        gaps_on = 1'b1;
    logic        rx_hold_req = 1'b0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

    task automatic model_reset();
        pu_mirror = MIRROR_HORIZ;
        pu_ctrl = '0;
        pu_mask = '0;
        pu_scroll_x = '0;
        pu_scroll_y = '0;
        pu_latch_hi = 1'b0;
        pu_vaddr = '0;
        pu_rbuf = '0;
        pu_status_phase = 1'b0;
        pu_oam_addr = '0;
        foreach (oam_mem[i]) oam_mem[i] = '0;
        foreach (nt_mem[i]) nt_mem[i] = '0;
        foreach (pal_mem[i]) pal_mem[i] = '0;
        foreach (chr_mem[i]) chr_mem[i] = '0;
    endtask

    // Nametable byte index: bank from bit 10 (horizontal) or bit 11 (vertical)
    function automatic logic [10:0] name_slot(input logic [13:0] a);
        logic bank;
        bank = pu_mirror ? a[10] : a[11];
        return {bank, a[9:0]};
    endfunction

    function automatic logic [7:0] vram_fetch(input logic [15:0] va);
        logic [13:0] a;
        a = va[13:0];
        if (a < NAME_BASE)
            return chr_mem[a[12:0]];
        if (a < PAL_BASE)
            return nt_mem[name_slot(a)];
        return 8'h00;
    endfunction

    task automatic vram_store(input logic [15:0] va, input logic [7:0] v);
        logic [13:0] a;
        logic [4:0]  p;
        a = va[13:0];
        p = a[4:0];
        if (a >= NAME_BASE && a < PAL_BASE)
            nt_mem[name_slot(a)] = v;
        else if (a >= PAL_BASE && a < PAL_END)
        begin
            pal_mem[p] = v;
            // backdrop entries of the sprite half alias the background half
            if (p[4] && p[1:0] == 2'b00)
                pal_mem[{1'b0, p[3:0]}] = v;
        end
    endtask

    task automatic step_vaddr();
        pu_vaddr = pu_vaddr + (pu_ctrl[CTRL_STEP_BIT] ? STEP_WIDE : STEP_NARROW);
    endtask

    // Expected read_data for one access, updating the model state
    task automatic model_access(input logic [1:0] act, input logic [2:0] sel,
                                input logic [7:0] din, input logic [12:0] paddr,
                                output logic [7:0] rd);
        rd = 8'h00;
        if (act == ACT_READ)
        begin
            case (sel)
                REG_STATUS:
                begin
                    rd = pu_status_phase ? 8'h00 : STATUS_FLAGS;
                    pu_status_phase = ~pu_status_phase;
                    pu_latch_hi = 1'b0;
                end
                REG_OAM_DATA:
                    rd = oam_mem[pu_oam_addr];
                REG_DATA:
                begin
                    rd = pu_rbuf;
                    pu_rbuf = vram_fetch(pu_vaddr);
                    step_vaddr();
                end
                default: ;
            endcase
        end
        else if (act == ACT_WRITE)
        begin
            case (sel)
                REG_CTRL:     pu_ctrl = din;
                REG_MASK:     pu_mask = din;
                REG_OAM_ADDR: pu_oam_addr = din;
                REG_OAM_DATA:
                begin
                    oam_mem[pu_oam_addr] = din;
                    pu_oam_addr = pu_oam_addr + 8'd1;
                end
                REG_SCROLL:
                begin
                    if (!pu_latch_hi)
                        pu_scroll_x = din;
                    else
                        pu_scroll_y = din;
                    pu_latch_hi = ~pu_latch_hi;
                end
                REG_ADDR:
                begin
                    if (!pu_latch_hi)
                        pu_vaddr[15:8] = din;
                    else
                        pu_vaddr[7:0] = din;
                    pu_latch_hi = ~pu_latch_hi;
                end
                REG_DATA:
                begin
                    vram_store(pu_vaddr, din);
                    step_vaddr();
                end
                default: ;
            endcase
        end
        else if (act == ACT_LOAD)
            chr_mem[paddr] = din;
    endtask

    // Offer one access in bursts with random gaps; predict at the transfer
    task automatic send_access(input logic [1:0] act, input logic [2:0] sel,
                               input logic [7:0] din, input logic [12:0] paddr);
        logic [7:0] rd;
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = gaps_on ? $urandom_range(0, 5) : 0;
            if (gap > 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid = 1'b1;
        action = act;
        reg_select = sel;
        data = din;
        pattern_address = paddr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        model_access(act, sel, din, paddr, rd);
        exp_read_q.push_back(rd);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic reg_write(input logic [2:0] sel, input logic [7:0] din);
        send_access(ACT_WRITE, sel, din, 13'($urandom));
    endtask

    task automatic reg_read(input logic [2:0] sel);
        send_access(ACT_READ, sel, 8'($urandom), 13'($urandom));
    endtask

    task automatic load_pattern(input logic [12:0] paddr, input logic [7:0] din);
        send_access(ACT_LOAD, 3'($urandom), din, paddr);
    endtask

    // Stop offering and let every expected result come out
    task automatic drain_results();
        in_valid = 1'b0;
        while (exp_read_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_mirror(input logic mode);
        drain_results();
        cfg_wr_en = 1'b1;
        cfg_wr_data = mode;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        pu_mirror = mode;
    endtask

    // Random VRAM address aimed at small windows so that data reads hit writes
    function automatic logic [15:0] pick_vaddr();
        logic [1:0] top;
        top = 2'($urandom);
        case ($urandom_range(0, 7))
            0, 1:    return {top, 1'b0, 8'h00, 5'($urandom)};
            2, 3, 4: return {top, 1'b1, 1'($urandom), 2'($urandom), 6'h00, 4'($urandom)};
            5:       return {top, 6'h3f, 2'b00, 6'($urandom)};
            6:       return {top, 6'h3f, 8'($urandom)};
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic vram_sequence();
        logic [15:0] va;
        int n;
        va = pick_vaddr();
        n = $urandom_range(1, 8);
        // an occasional missing status read leaves the toggle out of step
        if ($urandom_range(0, 7) != 0)
            reg_read(REG_STATUS);
        reg_write(REG_ADDR, va[15:8]);
        reg_write(REG_ADDR, va[7:0]);
        repeat (n)
        begin
            if ($urandom_range(0, 1))
                reg_read(REG_DATA);
            else
                reg_write(REG_DATA, 8'($urandom));
        end
    endtask

    task automatic oam_sequence();
        logic [7:0] base;
        base = ($urandom_range(0, 3) == 0) ? 8'hfe : 8'($urandom);
        reg_write(REG_OAM_ADDR, base);
        repeat ($urandom_range(1, 4))
            reg_write(REG_OAM_DATA, 8'($urandom));
        reg_write(REG_OAM_ADDR, base + 8'($urandom_range(0, 3)));
        reg_read(REG_OAM_DATA);
    endtask

    task automatic load_sequence();
        repeat ($urandom_range(1, 4))
        begin
            if ($urandom_range(0, 1))
                load_pattern({8'h00, 5'($urandom)}, 8'($urandom));
            else
                load_pattern(13'($urandom), 8'($urandom));
        end
    endtask

    task automatic run_random_phase(input int n_items, input logic mode,
                                    input logic with_pressure);
        int target;
        int hold_at;
        int pause_at;
        logic held;
        logic paused;
        write_mirror(mode);
        target = items_sent + n_items;
        hold_at = items_sent + n_items / 3;
        pause_at = items_sent + (2 * n_items) / 3;
        held = 1'b0;
        paused = 1'b0;
        while (items_sent < target)
        begin
            if (with_pressure && !held && items_sent >= hold_at)
            begin
                rx_hold_req = 1'b1;
                held = 1'b1;
            end
            if (with_pressure && !paused && items_sent >= pause_at)
            begin
                drain_results();
                paused = 1'b1;
            end
            gaps_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: vram_sequence();
                4:          oam_sequence();
                5:
                begin
                    reg_write(REG_SCROLL, 8'($urandom));
                    reg_write(REG_SCROLL, 8'($urandom));
                end
                6:          load_sequence();
                7:          reg_write(REG_CTRL, 8'($urandom));
                default:
                    repeat ($urandom_range(1, 4))
                        send_access(2'($urandom), 3'($urandom), 8'($urandom),
                                    13'($urandom));
            endcase
        end
    endtask

    // Reads of every register straight after reset, plus the unused action
    task automatic test_reset_state();
        for (int s = 0; s < 8; s++)
            reg_read(3'(s));
        send_access(ACT_NONE, REG_DATA, 8'hff, 13'h1fff);
    endtask

    // Mask, status write, sprite address wrap and scroll pair
    task automatic test_register_file();
        reg_write(REG_MASK, 8'hff);
        reg_write(REG_STATUS, 8'hff);
        reg_write(REG_OAM_ADDR, 8'hff);
        reg_write(REG_OAM_DATA, 8'ha5);
        reg_write(REG_OAM_ADDR, 8'hff);
        reg_read(REG_OAM_DATA);
        reg_write(REG_SCROLL, 8'h00);
        reg_write(REG_SCROLL, 8'hff);
    endtask

    // Data port: pattern read-only, buffered reads, palette alias, ignored
    // palette tail, step of 32 and 16-bit address wrap
    task automatic test_vram_port();
        load_pattern(13'h1fff, 8'h5a);
        reg_write(REG_ADDR, 8'hdf);
        reg_write(REG_ADDR, 8'hff);
        reg_write(REG_DATA, 8'h33);
        reg_write(REG_DATA, 8'h81);
        reg_write(REG_ADDR, 8'hdf);
        reg_write(REG_ADDR, 8'hff);
        reg_read(REG_DATA);
        reg_read(REG_DATA);
        reg_write(REG_CTRL, 8'h04);
        reg_write(REG_ADDR, 8'h3f);
        reg_write(REG_ADDR, 8'h10);
        reg_write(REG_DATA, 8'hc3);
        reg_write(REG_DATA, 8'h99);
        reg_read(REG_DATA);
        reg_write(REG_ADDR, 8'hff);
        reg_write(REG_ADDR, 8'hf0);
        reg_read(REG_DATA);
        reg_read(REG_DATA);
    endtask

    task automatic test_random_traffic();
        run_random_phase(440, MIRROR_VERT, 1'b0);
        run_random_phase(440, MIRROR_HORIZ, 1'b0);
        run_random_phase(440, logic'($urandom_range(0, 1)), 1'b0);
    endtask

    // Long receiver hold-off to fill the block, then a full drain mid-phase
    task automatic test_backpressure();
        run_random_phase(440, MIRROR_VERT, 1'b1);
    endtask

    // Receiver: own stall pattern, switched at random among four modes
    initial
    begin
        int hold_left;
        int mode_left;
        int rx_mode;
        hold_left = 0;
        mode_left = 0;
        rx_mode = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else
            begin
                case (rx_mode)
                    0:       out_ready = 1'b1;
                    1:       out_ready = ($urandom_range(0, 3) != 0);
                    2:       out_ready = ($urandom_range(0, 3) == 0);
                    default: out_ready = ~out_ready;
                endcase
            end
        end
    end

    // Result checker: each transfer against the oldest expectation
    always @(posedge clk)
    begin
        logic [7:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (exp_read_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_SHOWN)
                    $display("unexpected result: read_data %02h", read_data);
            end
            else
            begin
                want = exp_read_q.pop_front();
                if (read_data !== want)
                begin
                    fail_count++;
                    if (fail_count <= MAX_SHOWN)
                        $display("read_data mismatch: expected %02h, got %02h",
                                 want, read_data);
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_READ;
        reg_select = REG_CTRL;
        data = 8'h00;
        pattern_address = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 1'b0;
        model_reset();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_register_file();
        test_vram_port();
        test_random_traffic();
        test_backpressure();
        drain_results();

        if (fail_count == 0 && exp_read_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* ppu_register_port_core.f */
design/rpc_pkg.sv
design/rpc_ram.sv
design/rpc_ctrl.sv
design/rpc_datapath.sv
design/ppu_register_port_core.sv
sim/tb_top.sv
